[rtl/fir_linear_convolution_defines.svh]
// Assertion macros for the checker file of the FIR block.
`ifndef FIR_LINEAR_CONVOLUTION_DEFINES_SVH
`define FIR_LINEAR_CONVOLUTION_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/flc_pkg.sv]
// Types and constants shared by the FIR convolution block and its checker.
package flc_pkg;

  localparam int SMP_W  = 16;
  localparam int CIDX_W = 5;
  localparam int TAP_W  = 6;
  localparam int ACC_W  = 40;
  localparam int PROD_W = 2 * SMP_W;
  localparam int IN_W   = 40;
  localparam int CMP_W  = 8;

  // Item kinds carried on in_tuser.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

[rtl/fir_linear_convolution.sv]
// Direct-form FIR linear convolution on one shared multiply-accumulate unit.
//
//   Port group  Direction  Contents
//   in_*        slave      sample items and coefficient load items
//   out_*       master     one convolution output per result item
//   cfg_*       write      tap_count register
//
// A load item leaves the input ready. A sample item issues one tap read per
// effective tap, as does each tail output after a sample marked last; the
// single multiplier handles one tap per cycle, and each tap passes the read
// registers and the product register before the sum goes out. Reset (rst_n, synchronous)
// clears the delay line valid bits and the control state at once; the
// coefficient memory is not cleared. A result waiting in the output register
// does not block input, but the next result waits until that one is taken.
module fir_linear_convolution #(
  parameter int MAX_TAPS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // in_tdata: sample_value[15:0], coef_index[20:16], coef_value[36:21], zero[39:37]
  input  logic [flc_pkg::IN_W-1:0] in_tdata,
  // in_tuser: op
  input  logic                     in_tuser,
  // in_tlast: last_sample
  input  logic                     in_tlast,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // out_tdata: filtered_value[39:0]
  output logic [flc_pkg::ACC_W-1:0] out_tdata,
  // out_tlast: last_output
  output logic                     out_tlast,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic                     cfg_wr_en,
  input  logic [flc_pkg::TAP_W-1:0] cfg_wr_data
);

  import flc_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_TAPS - 1);

  // Memories.
  smp_t coef_mem [MAX_TAPS];
  smp_t dly_mem  [MAX_TAPS];

  // Control and datapath registers.
  state_t             state_r, state_nxt;
  logic [TAP_W-1:0]   tap_count_r, tap_count_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      iss_cnt_r, iss_cnt_nxt;
  logic [CW-1:0]      taps_r, taps_nxt;
  logic [CW-1:0]      tail_r, tail_nxt;
  logic               last_r, last_nxt;
  logic [MAX_TAPS-1:0] dly_vld_r, dly_vld_nxt;
  logic               rd_v_r, rd_v_nxt;
  logic               mul_v_r;
  smp_t               coef_q_r;
  smp_t               dly_q_r;
  logic               dly_ok_r;
  prod_t              prod_r;
  acc_t               acc_r, acc_nxt;
  logic [ACC_W-1:0]   out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Input fields.
  smp_t               in_sample;
  logic [CIDX_W-1:0]  in_cidx;
  smp_t               in_coef;
  logic               in_acc;
  logic               coef_idx_ok;
  logic               coef_we;
  logic               dly_we;
  logic [CW-1:0]      taps_eff;
  logic [AW-1:0]      wp_inc;
  logic               out_load;
  smp_t               dly_op;

  assign in_sample   = in_tdata[15:0];
  assign in_cidx     = in_tdata[20:16];
  assign in_coef     = in_tdata[36:21];
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign coef_idx_ok = (CMP_W'(in_cidx) < CMP_W'(MAX_TAPS));
  assign coef_we     = in_acc && (in_tuser == OP_LOAD) && coef_idx_ok;
  assign dly_we      = in_acc && (in_tuser == OP_SAMPLE);
  assign wp_inc      = (wp_r == ADDR_TOP) ? '0 : wp_r + 1'b1;

  assign out_tdata   = out_data_r;
  assign out_tlast   = out_last_r;
  assign out_tvalid  = out_valid_r;

  // Zero is treated as one tap, anything above the delay depth as the depth.
  always_comb begin
    priority if (tap_count_r == '0) begin
      taps_eff = CW'(1);
    end else if (CMP_W'(tap_count_r) > CMP_W'(MAX_TAPS)) begin
      taps_eff = CW'(MAX_TAPS);
    end else begin
      taps_eff = CW'(tap_count_r);
    end
  end

  assign out_load = (state_r == ST_DONE) && !rd_v_r && !mul_v_r &&
                    (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    tap_count_nxt = cfg_wr_en ? cfg_wr_data : tap_count_r;
    wp_nxt        = wp_r;
    rd_ptr_nxt    = rd_ptr_r;
    iss_cnt_nxt   = iss_cnt_r;
    taps_nxt      = taps_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    dly_vld_nxt   = dly_vld_r;
    rd_v_nxt      = 1'b0;
    acc_nxt       = mul_v_r ? acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r} : acc_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = (out_valid_r && !out_tready) ? 1'b1 : 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (dly_we) begin
          wp_nxt              = wp_inc;
          dly_vld_nxt[wp_inc] = 1'b1;
          rd_ptr_nxt          = wp_inc;
          iss_cnt_nxt         = '0;
          acc_nxt             = '0;
          taps_nxt            = taps_eff;
          tail_nxt            = in_tlast ? taps_eff - 1'b1 : '0;
          last_nxt            = in_tlast;
          state_nxt           = ST_MAC;
        end
      end
      ST_MAC: begin
        rd_v_nxt    = 1'b1;
        rd_ptr_nxt  = (rd_ptr_r == '0) ? ADDR_TOP : rd_ptr_r - 1'b1;
        iss_cnt_nxt = iss_cnt_r + 1'b1;
        if (iss_cnt_r == taps_r - 1'b1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_nxt  = acc_r;
          out_last_nxt  = last_r && (tail_r == '0);
          out_valid_nxt = 1'b1;
          if (tail_r != '0) begin
            // Shifting a zero in is just marking the new newest entry empty.
            tail_nxt            = tail_r - 1'b1;
            wp_nxt              = wp_inc;
            dly_vld_nxt[wp_inc] = 1'b0;
            rd_ptr_nxt          = wp_inc;
            iss_cnt_nxt         = '0;
            acc_nxt             = '0;
            state_nxt           = ST_MAC;
          end else begin
            if (last_r) begin
              dly_vld_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_W'(1);
      wp_r        <= '0;
      rd_ptr_r    <= '0;
      iss_cnt_r   <= '0;
      taps_r      <= CW'(1);
      tail_r      <= '0;
      last_r      <= 1'b0;
      dly_vld_r   <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_count_r <= tap_count_nxt;
      wp_r        <= wp_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      taps_r      <= taps_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      dly_vld_r   <= dly_vld_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= rd_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed.
  assign dly_op = dly_ok_r ? dly_q_r : '0;

  always_ff @(posedge clk) begin
    dly_ok_r   <= dly_vld_r[rd_ptr_r];
    prod_r     <= coef_q_r * dly_op;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Coefficient memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[AW'(in_cidx)] <= in_coef;
    end
  end

  // The tap number pairs coefficient i with the entry i places behind the newest.
  always_ff @(posedge clk) begin
    coef_q_r <= coef_mem[iss_cnt_r[AW-1:0]];
  end

  // Delay line memory, used as a circular buffer with newest entry at wp_r.
  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[wp_inc] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    dly_q_r <= dly_mem[rd_ptr_r];
  end

endmodule

[rtl/flc_checker.sv]
// Port-level checker for the FIR convolution block, bound to its top level.
`include "fir_linear_convolution_defines.svh"

module flc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic [flc_pkg::IN_W-1:0]  in_tdata,
  input logic                      in_tuser,
  input logic                      in_tlast,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [flc_pkg::ACC_W-1:0] out_tdata,
  input logic                      out_tlast,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic                      cfg_wr_en,
  input logic [flc_pkg::TAP_W-1:0] cfg_wr_data
);

  import flc_pkg::*;

  // A waiting result must hold still until it is taken.
  `FLC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // A sample item starts the multiply loop, so input closes at once.
  `FLC_ASSERT_NEXT(a_sample_busy, in_tvalid && in_tready && (in_tuser == OP_SAMPLE),
    !in_tready, "input still open after a sample item")

  // A coefficient load finishes in its own cycle.
  `FLC_ASSERT_NEXT(a_load_quick, in_tvalid && in_tready && (in_tuser == OP_LOAD),
    in_tready, "input closed after a load item")

  // A new result only comes out of the busy phase.
  `FLC_ASSERT_NOW(a_result_from_busy, $rose(out_tvalid),
    $past(!in_tready), "result appeared without a busy phase")

endmodule

bind fir_linear_convolution flc_checker u_flc_checker (.*);

[verif/tb.sv]
// Self-checking testbench for the streaming FIR linear convolution block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flc_pkg::*;

  localparam int TAPS_MAX = 32;
  localparam int SETTLE_CYCLES = 48;
  localparam smp_t SMP_MIN = 16'sh8000;
  localparam smp_t SMP_MAX = 16'sh7fff;

  typedef struct {
    acc_t value;
    logic is_end;
  } fir_out_t;

  // Keeps its own copy of the coefficients, delay line and tap count and
  // queues the outputs that each accepted item must produce.
  class conv_tracker;
    smp_t coef_mem [TAPS_MAX];
    smp_t delay_mem [TAPS_MAX];
    logic [TAP_W-1:0] tap_reg;
    fir_out_t outputs_due [$];
    int errors;
    int reported;

    function void clear();
      tap_reg = TAP_W'(1);
      foreach (coef_mem[k]) coef_mem[k] = '0;
      foreach (delay_mem[k]) delay_mem[k] = '0;
      outputs_due.delete();
      errors = 0;
      reported = 0;
    endfunction

    function void set_taps(logic [TAP_W-1:0] v);
      tap_reg = v;
    endfunction

    function int active_taps();
      if (tap_reg == 0) return 1;
      if (tap_reg > TAPS_MAX) return TAPS_MAX;
      return int'(tap_reg);
    endfunction

    function void shift_and_sum(smp_t s, int n, logic is_end);
      acc_t acc;
      fir_out_t r;
      for (int k = TAPS_MAX - 1; k > 0; k--) delay_mem[k] = delay_mem[k-1];
      delay_mem[0] = s;
      acc = '0;
      for (int k = 0; k < n; k++) acc += coef_mem[k] * delay_mem[k];
      r.value = acc;
      r.is_end = is_end;
      outputs_due.push_back(r);
    endfunction

    function void take_item(logic op, smp_t smp, logic lst, logic [CIDX_W-1:0] cidx,
                            smp_t cval);
      int n;
      n = active_taps();
      if (op == OP_LOAD) begin
        coef_mem[cidx] = cval;
        return;
      end
      shift_and_sum(smp, n, lst && n == 1);
      if (lst) begin
        // The tail flushes the delay line with zeros, then the line is cleared.
        for (int t = 1; t < n; t++) shift_and_sum('0, n, t == n - 1);
        foreach (delay_mem[k]) delay_mem[k] = '0;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (reported < 10) begin
        $display("%0t: %s", $realtime, msg);
        reported++;
      end
    endfunction

    function void check_output(acc_t got, logic got_last);
      fir_out_t want;
      if (outputs_due.size() == 0) begin
        flag($sformatf("unexpected output value %0d last %0b", got, got_last));
        return;
      end
      want = outputs_due.pop_front();
      if (want.value !== got)
        flag($sformatf("output value: expected %0d, got %0d", want.value, got));
      if (want.is_end !== got_last)
        flag($sformatf("output last: expected %0b, got %0b", want.is_end, got_last));
    endfunction

    function int pending();
      return outputs_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic [IN_W-1:0] in_tdata;
  logic in_tuser;
  logic in_tlast;
  logic in_tvalid;
  logic in_tready;
  logic [ACC_W-1:0] out_tdata;
  logic out_tlast;
  logic out_tvalid;
  logic out_tready;
  logic cfg_wr_en;
  logic [TAP_W-1:0] cfg_wr_data;

  int idle_pct;
  conv_tracker book;

  fir_linear_convolution #(.MAX_TAPS(TAPS_MAX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_output(out_tdata, out_tlast);
  end

  function automatic smp_t pick_value();
    case ($urandom_range(9))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2: return '0;
      default: return smp_t'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic op, input smp_t smp, input logic lst,
                           input logic [CIDX_W-1:0] cidx, input smp_t cval);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tlast <= lst;
    in_tdata <= {3'b000, cval, cidx, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.take_item(op, smp, lst, cidx, cval);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [CIDX_W-1:0] cidx, input smp_t cval);
    send_item(OP_LOAD, smp_t'($urandom), 1'($urandom), cidx, cval);
  endtask

  task automatic send_sample(input smp_t smp, input logic lst);
    send_item(OP_SAMPLE, smp, lst, CIDX_W'($urandom), smp_t'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_taps(input logic [TAP_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    book.set_taps(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic fill_coefs(input logic all_min);
    for (int k = 0; k < TAPS_MAX; k++) send_load(CIDX_W'(k), all_min ? SMP_MIN : pick_value());
  endtask

  // Mostly complete sequences with random content, some stray loads and
  // unterminated samples mixed in.
  task automatic run_phase(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) != 0) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(15) == 0) begin
            send_load(CIDX_W'($urandom_range(TAPS_MAX - 1)), pick_value());
            sent++;
          end
          send_sample(pick_value(), k == len - 1);
          sent++;
        end
      end else if ($urandom_range(1) == 0) begin
        send_load(CIDX_W'($urandom_range(TAPS_MAX - 1)), pick_value());
        sent++;
      end else begin
        send_sample(pick_value(), 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    int taps_plan [8];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_SAMPLE;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_pct = 24;
    book = new();
    book.clear();
    taps_plan = '{63, 0, 33, 32, 1, 2, 0, 0};
    taps_plan[6] = $urandom_range(3, 31);
    taps_plan[7] = $urandom_range(63);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset tap count of one, extreme products.
    send_item(OP_LOAD, 16'sh1234, 1'b1, 5'd0, SMP_MIN);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample('0, 1'b1);
    drain_results();
    // A tap count of zero behaves as one.
    write_taps(6'd0);
    send_load(5'd0, SMP_MAX);
    send_sample(SMP_MIN, 1'b1);
    drain_results();
    write_taps(6'd4);
    send_load(5'd1, -16'sd1);
    send_load(5'd2, SMP_MAX);
    send_load(5'd3, SMP_MIN);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b1);
    // Ignored fields carry data on both item kinds.
    send_item(OP_SAMPLE, 16'sd77, 1'b0, 5'd31, SMP_MAX);
    send_item(OP_LOAD, -16'sd1, 1'b1, 5'd31, 16'sd12345);
    send_sample(16'sd2, 1'b1);
    // Change the tap count while a sequence is still open.
    send_sample(16'sd100, 1'b0);
    drain_results();
    write_taps(6'd3);
    send_sample(16'sd5, 1'b0);
    drain_results();
    write_taps(6'd2);
    send_sample(-16'sd9, 1'b1);

    fill_coefs(1'b0);
    foreach (taps_plan[p]) begin
      drain_results();
      write_taps(TAP_W'(taps_plan[p]));
      idle_pct = (p == 2) ? 0 : 24;
      if (p == 3) begin
        // Largest possible sum: every product at its maximum.
        fill_coefs(1'b1);
        for (int k = 0; k <= TAPS_MAX; k++) send_sample(SMP_MIN, k == TAPS_MAX);
        fill_coefs(1'b0);
      end
      run_phase(16);
    end

    drain_results();
    book.errors += book.pending();
    if (book.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
